>>> hdl/stride_prediction_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Stride prediction table assertion macros
// Shared shorthand for the concurrent checks of the stride table unit.
// ----------------------------------------------------------------------------
`ifndef STRIDE_PREDICTION_TABLE_UNIT_MACROS_SVH
`define STRIDE_PREDICTION_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/spt_pkg.sv
// ----------------------------------------------------------------------------
// Stride prediction table package
// Shared types, codes and confidence-machine functions of the stride table.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int PC_W       = 48;
   localparam int STRIDE_W   = 49;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CYCLES = PC_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_QUERY = 3'd1,
      OP_MARK  = 3'd2,
      OP_TRAIN = 3'd3,
      OP_TRACK = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CS_INIT   = 2'd0,
      CS_STEADY = 2'd1,
      CS_TRANS  = 2'd2,
      CS_NOPRED = 2'd3
   } conf_type;

   // Entry fields whose width does not depend on the set count.
   typedef struct packed {
      logic [PC_W-1:0]     last_addr;
      logic [STRIDE_W-1:0] stride;
      conf_type            conf;
      logic                prefetch_ok;
   } entry_body_type;

   // Table access controls driven by the sequencer.
   typedef struct packed {
      logic rd_en;
      logic entry_we;
      logic seen_we;
      logic seen_wd;
   } tbl_ctl_type;

   // Result item, lowest field in the lowest bits.
   typedef struct packed {
      logic                pad;
      logic [STRIDE_W-1:0] tracked_stride;
      logic                clear_vector_table;
      logic                wait_loop;
      logic                stride_match;
      logic                can_prefetch;
      logic                allocated;
      logic                tag_hit;
   } rsp_fields_type;

   function automatic conf_type conf_next(input conf_type cur, input logic corr);
      conf_type nxt;
      unique case (cur)
         CS_INIT:   nxt = corr ? CS_STEADY : CS_TRANS;
         CS_STEADY: nxt = corr ? CS_STEADY : CS_INIT;
         CS_TRANS:  nxt = corr ? CS_STEADY : CS_NOPRED;
         default:   nxt = corr ? CS_TRANS : CS_NOPRED;
      endcase
      return nxt;
   endfunction

   function automatic logic pf_next(input conf_type cur, input logic corr);
      logic pf;
      unique case (cur)
         CS_INIT:   pf = corr;
         CS_STEADY: pf = 1'b1;
         CS_TRANS:  pf = corr;
         default:   pf = 1'b0;
      endcase
      return pf;
   endfunction

endpackage

>>> hdl/spt_divider.sv
// ----------------------------------------------------------------------------
// Stride table index divider
// Splits a load PC into set index (remainder) and tag (quotient).
// ----------------------------------------------------------------------------
module spt_divider import spt_pkg::*; #(
   parameter int NUM_SETS = 64,
   parameter int IDX_W    = 6,
   parameter int TAG_W    = 42
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PC_W-1:0]  dividend,
   output logic             done,
   output logic [TAG_W-1:0] quotient,
   output logic [IDX_W-1:0] remainder
);

   localparam bit IS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
   localparam int LOG2    = $clog2(NUM_SETS);

   generate
      if (IS_POW2) begin : g_shift
         logic             done_ff;
         logic [TAG_W-1:0] quo_ff;
         logic [IDX_W-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               quo_ff <= TAG_W'(dividend >> LOG2);
               rem_ff <= IDX_W'(dividend & PC_W'(NUM_SETS - 1));
            end
         end

         assign done      = done_ff;
         assign quotient  = quo_ff;
         assign remainder = rem_ff;
      end else begin : g_long
         localparam int REM_W = LOG2 + 1;

         logic                 busy_ff;
         logic                 done_ff;
         logic [DIV_CNT_W-1:0] cnt_ff;
         logic [PC_W-1:0]      dvd_ff;
         logic [REM_W-1:0]     rem_ff;
         logic [PC_W-1:0]      dvd_in;
         logic [REM_W-1:0]     rem_in;

         // Restoring long division, a few quotient bits per cycle. The
         // dividend shifts out at the top while quotient bits enter below.
         always_comb begin
            dvd_in = dvd_ff;
            rem_in = rem_ff;
            for (int s = 0; s < DIV_STEPS; s++) begin
               rem_in = {rem_in[REM_W-2:0], dvd_in[PC_W-1]};
               dvd_in = {dvd_in[PC_W-2:0], 1'b0};
               if (rem_in >= REM_W'(NUM_SETS)) begin
                  rem_in    = rem_in - REM_W'(NUM_SETS);
                  dvd_in[0] = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= '0;
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            if (start) begin
               dvd_ff <= dividend;
               rem_ff <= '0;
            end else if (busy_ff) begin
               dvd_ff <= dvd_in;
               rem_ff <= rem_in;
            end
         end

         assign done      = done_ff;
         assign quotient  = TAG_W'(dvd_ff);
         assign remainder = IDX_W'(rem_ff);
      end
   endgenerate

endmodule

>>> hdl/spt_table.sv
// ----------------------------------------------------------------------------
// Stride table storage
// Entry memory and seen-mark memory, one read and one write port each.
// ----------------------------------------------------------------------------
module spt_table import spt_pkg::*; #(
   parameter int NUM_SETS = 64,
   parameter int IDX_W    = 6,
   parameter int TAG_W    = 42
) (
   input  logic           clock,
   input  tbl_ctl_type    ctl,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic           wr_valid,
   input  logic [TAG_W-1:0] wr_tag,
   input  entry_body_type wr_body,
   output logic           rd_valid,
   output logic [TAG_W-1:0] rd_tag,
   output entry_body_type rd_body,
   output logic           rd_seen
);

   localparam int BODY_W = $bits(entry_body_type);
   localparam int MAIN_W = 1 + TAG_W + BODY_W;

   logic [MAIN_W-1:0] main_mem [NUM_SETS];
   logic              seen_mem [NUM_SETS];
   logic [MAIN_W-1:0] main_rd_ff;
   logic              seen_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.entry_we) begin
         main_mem[wr_idx] <= {wr_valid, wr_tag, wr_body};
      end
      if (ctl.rd_en) begin
         main_rd_ff <= main_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.seen_we) begin
         seen_mem[wr_idx] <= ctl.seen_wd;
      end
      if (ctl.rd_en) begin
         seen_rd_ff <= seen_mem[rd_idx];
      end
   end

   assign rd_valid = main_rd_ff[MAIN_W-1];
   assign rd_tag   = main_rd_ff[MAIN_W-2 -: TAG_W];
   assign rd_body  = entry_body_type'(main_rd_ff[BODY_W-1:0]);
   assign rd_seen  = seen_rd_ff;

endmodule

>>> hdl/stride_prediction_table_unit.sv
// ----------------------------------------------------------------------------
// Stride prediction table unit
// Direct-mapped per-load stride table with loop tracking for vectorization.
// ----------------------------------------------------------------------------
// The unit handles one load item at a time. An item is accepted only while
// the sequencer is idle, its PC is split into set index and tag, the entry
// is read from a synchronous memory, updated and written back, and the
// result is placed in an output register that the consumer drains at its
// own pace; the next item may be accepted while that result still waits.
// With a power-of-two set count the split is a bit slice. With any other
// set count a long divider produces four quotient bits a cycle. An item
// that raises clear_vector_table is followed by a sweep over the seen-mark
// memory, one entry per cycle, during which the unit is busy. After reset
// a clearing pass invalidates every entry before the first item is
// accepted.
// ----------------------------------------------------------------------------
`include "stride_prediction_table_unit_macros.svh"

module stride_prediction_table_unit import spt_pkg::*; #(
   parameter int NUM_SETS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Input item: [47:0] load_pc, [95:48] eff_addr
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // Input item kind: [2:0] op
   input  logic [2:0]  req_tuser,
   // Result item: [0] tag_hit, [1] allocated, [2] can_prefetch,
   // [3] stride_match, [4] wait_loop, [5] clear_vector_table,
   // [54:6] tracked_stride, [55] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata
);

   localparam int IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int TAG_W = PC_W + 1 - $clog2(NUM_SETS + 1);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_UPD   = 5'b01000,
      ST_SWEEP = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   op_type              op_ff;
   logic [PC_W-1:0]     pc_ff;
   logic [PC_W-1:0]     addr_ff;
   logic [PC_W-1:0]     trk_pc_ff, trk_pc_in;
   logic [STRIDE_W-1:0] trk_stride_ff, trk_stride_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_fields_type      rsp_fields_ff, rsp_fields_in;

   logic                req_accept;
   logic                div_done;
   logic [TAG_W-1:0]    div_tag;
   logic [IDX_W-1:0]    div_idx;

   tbl_ctl_type         tbl_ctl;
   logic [IDX_W-1:0]    wr_idx;
   logic                wr_valid;
   logic [TAG_W-1:0]    wr_tag;
   entry_body_type      wr_body;
   logic                rd_valid;
   logic [TAG_W-1:0]    rd_tag;
   entry_body_type      rd_body;
   logic                rd_seen;

   logic                advance;
   logic                sweep_last;
   logic                hit;
   logic [STRIDE_W-1:0] new_stride;
   logic                corr;
   conf_type            trained_conf;
   logic                trained_pf;

   // Decisions of the update step, before gating with advance.
   logic                upd_entry_we;
   logic                upd_seen_we;
   logic                upd_seen_wd;
   logic                upd_clr;
   entry_body_type      upd_body;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign advance    = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_tready);
   assign sweep_last = (sweep_ff == IDX_W'(NUM_SETS - 1));

   spt_divider #(
      .NUM_SETS (NUM_SETS),
      .IDX_W    (IDX_W),
      .TAG_W    (TAG_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_tdata[47:0]),
      .done      (div_done),
      .quotient  (div_tag),
      .remainder (div_idx)
   );

   spt_table #(
      .NUM_SETS (NUM_SETS),
      .IDX_W    (IDX_W),
      .TAG_W    (TAG_W)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .rd_idx   (div_idx),
      .wr_idx   (wr_idx),
      .wr_valid (wr_valid),
      .wr_tag   (wr_tag),
      .wr_body  (wr_body),
      .rd_valid (rd_valid),
      .rd_tag   (rd_tag),
      .rd_body  (rd_body),
      .rd_seen  (rd_seen)
   );

   // Training of the entry that was read: new stride, confidence step.
   assign hit          = rd_valid && (rd_tag == div_tag);
   assign new_stride   = {1'b0, addr_ff} - {1'b0, rd_body.last_addr};
   assign corr         = (new_stride == rd_body.stride) && (new_stride != '0);
   assign trained_conf = conf_next(rd_body.conf, corr);
   assign trained_pf   = pf_next(rd_body.conf, corr);

   // Update step. A fresh entry is the default write image; training
   // replaces it with the trained fields.
   always_comb begin
      rsp_fields_in  = '0;
      upd_entry_we   = 1'b0;
      upd_seen_we    = 1'b0;
      upd_seen_wd    = 1'b0;
      upd_clr        = 1'b0;
      upd_body       = '{last_addr: '0, stride: '0, conf: CS_INIT, prefetch_ok: 1'b0};
      trk_pc_in      = trk_pc_ff;
      trk_stride_in  = trk_stride_ff;
      rsp_fields_in.tag_hit = hit;

      unique case (op_ff)
         OP_ALLOC: begin
            if (!hit) begin
               upd_entry_we            = 1'b1;
               upd_seen_we             = 1'b1;
               rsp_fields_in.allocated = 1'b1;
            end
         end
         OP_QUERY: begin
            rsp_fields_in.can_prefetch = hit && rd_body.prefetch_ok;
         end
         OP_MARK: begin
            if (hit) begin
               rsp_fields_in.can_prefetch = rd_body.prefetch_ok;
               if (rd_body.prefetch_ok) begin
                  // The sweep clears every mark and sets this entry's own.
                  upd_clr = 1'b1;
                  if (trk_pc_ff == pc_ff) begin
                     rsp_fields_in.wait_loop = 1'b1;
                  end else begin
                     trk_pc_in = pc_ff;
                  end
               end else begin
                  upd_seen_we = 1'b1;
                  upd_seen_wd = 1'b1;
               end
            end
         end
         OP_TRAIN: begin
            if (hit) begin
               upd_entry_we = 1'b1;
               upd_body     = '{last_addr: addr_ff, stride: new_stride,
                                conf: trained_conf, prefetch_ok: trained_pf};
               rsp_fields_in.stride_match = corr;
               rsp_fields_in.can_prefetch = trained_pf;
            end
         end
         OP_TRACK: begin
            upd_entry_we = 1'b1;
            if (hit) begin
               upd_body = '{last_addr: addr_ff, stride: new_stride,
                            conf: trained_conf, prefetch_ok: trained_pf};
               rsp_fields_in.stride_match = corr;
               rsp_fields_in.can_prefetch = trained_pf;
               if (trained_pf && rd_seen) begin
                  upd_clr = 1'b1;
                  if (trk_pc_ff == pc_ff) begin
                     rsp_fields_in.wait_loop = 1'b1;
                  end else begin
                     trk_pc_in = pc_ff;
                  end
               end else if (trained_pf) begin
                  upd_seen_we = 1'b1;
                  upd_seen_wd = 1'b1;
               end
            end else begin
               // Replacement on a miss starts from the current address.
               upd_body.last_addr      = addr_ff;
               upd_seen_we             = 1'b1;
               rsp_fields_in.allocated = 1'b1;
            end
            if (trk_pc_in == pc_ff) begin
               trk_stride_in = hit ? new_stride : '0;
            end
         end
         default: begin
            rsp_fields_in.tag_hit = 1'b0;
         end
      endcase

      rsp_fields_in.clear_vector_table = upd_clr;
      rsp_fields_in.tracked_stride     = trk_stride_in;
   end

   // Table port steering: the clearing passes own the write port while
   // they run; otherwise the update step writes the entry it read.
   always_comb begin
      tbl_ctl.rd_en    = (state_ff == ST_DIV) && div_done;
      tbl_ctl.entry_we = advance && upd_entry_we;
      tbl_ctl.seen_we  = advance && upd_seen_we;
      tbl_ctl.seen_wd  = upd_seen_wd;
      wr_idx           = div_idx;
      wr_valid         = 1'b1;
      wr_tag           = div_tag;
      wr_body          = upd_body;
      if (state_ff == ST_INIT) begin
         tbl_ctl.entry_we = 1'b1;
         tbl_ctl.seen_we  = 1'b1;
         tbl_ctl.seen_wd  = 1'b0;
         wr_idx           = sweep_ff;
         wr_valid         = 1'b0;
      end else if (state_ff == ST_SWEEP) begin
         tbl_ctl.seen_we  = 1'b1;
         tbl_ctl.seen_wd  = (sweep_ff == div_idx);
         wr_idx           = sweep_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = '0;
      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (advance) begin
               state_in = upd_clr ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         trk_pc_ff     <= '0;
         trk_stride_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            trk_pc_ff     <= trk_pc_in;
            trk_stride_ff <= trk_stride_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= op_type'(req_tuser);
         pc_ff   <= req_tdata[47:0];
         addr_ff <= req_tdata[95:48];
      end
      if (advance) begin
         rsp_fields_ff <= rsp_fields_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_fields_ff;

   `SPT_ASSERT_IMPLY(a_wait_implies_clear, clock, reset,
      rsp_valid_ff && rsp_fields_ff.wait_loop, rsp_fields_ff.clear_vector_table,
      "wait_loop reported without a seen-mark clear")
   `SPT_ASSERT_IMPLY(a_match_implies_hit, clock, reset,
      rsp_valid_ff && rsp_fields_ff.stride_match,
      rsp_fields_ff.tag_hit && !rsp_fields_ff.allocated,
      "stride match reported on an entry that did not hit")
   `SPT_ASSERT_NEXT(a_clear_starts_sweep, clock, reset,
      advance && upd_clr, state_ff == ST_SWEEP && sweep_ff == '0,
      "seen-mark clear did not start a sweep from the first set")
   `SPT_ASSERT_NEXT(a_stall_holds_update, clock, reset,
      state_ff == ST_UPD && rsp_valid_ff && !rsp_tready,
      state_ff == ST_UPD && $stable(rsp_fields_ff),
      "update step moved on while the result register was full")

endmodule
